// ===== rtl/gcc_pkg.sv =====
// shared constants, types and codes for the greedy constraint coloring block
// no dependencies; every other file imports this package
package gcc_pkg;

  localparam int NUM_POINTS = 4096;
  localparam int COLOR_CAP  = 64;
  localparam int MAX_PTS    = 8;
  localparam int ADDR_W     = $clog2(NUM_POINTS);
  localparam int MASK_W     = 64;
  localparam int COLOR_W    = 6;
  localparam int CNT_W      = 7;
  localparam int PT_W       = 12;
  localparam int PCNT_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int GRP_N      = 8;
  localparam int GRP_W      = 8;

  localparam logic ACT_COLOR = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);

  typedef struct packed {
    logic              action;
    logic [PCNT_W-1:0] point_count;
    logic [PT_W-1:0]   point_0;
    logic [PT_W-1:0]   point_1;
    logic [PT_W-1:0]   point_2;
    logic [PT_W-1:0]   point_3;
    logic [PT_W-1:0]   point_4;
    logic [PT_W-1:0]   point_5;
    logic [PT_W-1:0]   point_6;
    logic [PT_W-1:0]   point_7;
  } cmd_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   colors_used;
    logic               overflow;
  } res_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MASK_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               found;
    logic [COLOR_W-1:0] color;
  } pick_res_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_PICK  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

// ===== rtl/gcc_if.sv =====
// valid/ready channel interfaces for command items and result items
// depends on gcc_pkg for the payload types
interface gcc_cmd_if;
  import gcc_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gcc_res_if;
  import gcc_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/greedy_constraint_coloring.sv =====
// greedy constraint coloring top level: sequencer, registers and channels
// depends on gcc_pkg, gcc_if, gcc_mem and gcc_pick
// usage:
//   cmd carries one item: a constraint (action 0, up to eight point ids and
//   a count) or a clear (action 1). res returns one item per command: the
//   color, the running color count and an overflow flag.
//   cfg_we/cfg_wdata write color_limit (reset 64); the user must do so only
//   while idle, as the block itself does not enforce it.
// sequence:
//   a constraint's point masks are read through the single read port and
//   ORed, the pipelined first-free search picks a color, the masks are written
//   back, then the result register is loaded; cmd.ready is low meanwhile, so
//   no new item is taken until that result is loaded. a clear sweeps all 4096
//   point masks to zero, one entry per cycle; its result is loaded after it.
// reset: rst is synchronous; a sweep then clears all 4096 point masks, with
//   cmd.ready low until it is done
// stalls:
//   the result sits in an output register until res.ready; a following item
//   can be taken and worked on, but it waits at its end for the register
module greedy_constraint_coloring
  import gcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  gcc_cmd_if.sink          cmd,
  gcc_res_if.source        res
);

  state_t             state;
  logic [CNT_W-1:0]   color_limit;
  logic [CNT_W-1:0]   color_count;
  logic [ADDR_W-1:0]  clr_addr;
  logic               clr_reply;
  logic [PCNT_W-1:0]  cnt;
  logic [ADDR_W-1:0]  ids [MAX_PTS];
  logic [MAX_PTS-1:0] pt_valid;
  logic [MASK_W-1:0]  slot_mask [MAX_PTS];
  logic [MASK_W-1:0]  used;
  logic [COLOR_W-1:0] res_color;
  logic               res_ovf;
  logic               out_valid;
  res_item_t          out_data;

  mem_req_t           req;
  logic [MASK_W-1:0]  rdata;
  logic [MASK_W-1:0]  busy;
  logic [MASK_W-1:0]  allowed;
  logic [CNT_W-1:0]   eff_limit;
  pick_res_t          pick;
  logic [PT_W-1:0]    pts [MAX_PTS];
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  prev_slot;
  logic               load_out;
  logic [CNT_W-1:0]   next_used;

  gcc_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  gcc_pick u_pick (
    .clk  (clk),
    .busy (busy),
    .pick (pick)
  );

  assign pts[0] = cmd.data.point_0;
  assign pts[1] = cmd.data.point_1;
  assign pts[2] = cmd.data.point_2;
  assign pts[3] = cmd.data.point_3;
  assign pts[4] = cmd.data.point_4;
  assign pts[5] = cmd.data.point_5;
  assign pts[6] = cmd.data.point_6;
  assign pts[7] = cmd.data.point_7;

  assign slot      = cnt[SLOT_W-1:0];
  assign prev_slot = slot - SLOT_W'(1);

  // colors at or above the effective limit count as taken
  assign eff_limit = (color_limit > CNT_W'(COLOR_CAP)) ? CNT_W'(COLOR_CAP) : color_limit;
  assign allowed   = (eff_limit >= CNT_W'(MASK_W)) ? '1
                   : ((MASK_W'(1) << eff_limit) - MASK_W'(1));
  assign busy      = used | ~allowed;

  assign next_used = CNT_W'(pick.color) + CNT_W'(1);

  always_comb begin
    req       = '0;
    req.raddr = ids[slot];
    if (state == ST_CLEAR) begin
      req.we    = 1'b1;
      req.waddr = clr_addr;
      req.wdata = '0;
    end else if (state == ST_WRITE) begin
      req.we    = pick.found && pt_valid[slot];
      req.waddr = ids[slot];
      req.wdata = slot_mask[slot] | (MASK_W'(1) << pick.color);
    end
  end

  assign cmd.ready = (state == ST_IDLE);
  assign load_out  = (state == ST_DONE) && (!out_valid || res.ready);
  assign res.valid = out_valid;
  assign res.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      color_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      color_count <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(NUM_POINTS - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? ST_DONE : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (cmd.valid) begin
            cnt <= '0;
            if (cmd.data.action == ACT_CLEAR) begin
              color_count <= '0;
              clr_reply   <= 1'b1;
              state       <= ST_CLEAR;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (cnt == PCNT_W'(MAX_PTS)) begin
            cnt   <= '0;
            state <= ST_PICK;
          end else begin
            cnt <= cnt + PCNT_W'(1);
          end
        end
        ST_PICK: begin
          // wait out the search pipeline
          if (cnt == PCNT_W'(1)) begin
            cnt   <= '0;
            state <= ST_WRITE;
          end else begin
            cnt <= cnt + PCNT_W'(1);
          end
        end
        ST_WRITE: begin
          if (cnt == PCNT_W'(MAX_PTS - 1)) begin
            cnt   <= '0;
            state <= ST_DONE;
            if (pick.found && next_used > color_count) color_count <= next_used;
          end else begin
            cnt <= cnt + PCNT_W'(1);
          end
        end
        ST_DONE: begin
          if (load_out) begin
            clr_reply <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      used      <= '0;
      res_color <= '0;
      res_ovf   <= 1'b0;
      for (int i = 0; i < MAX_PTS; i++) begin
        ids[i]      <= ADDR_W'(pts[i]);
        pt_valid[i] <= (PCNT_W'(i) < cmd.data.point_count) && (32'(pts[i]) < NUM_POINTS);
      end
    end
    // read data comes back in the cycle after its address
    if (state == ST_READ && cnt != '0) begin
      slot_mask[prev_slot] <= rdata;
      if (pt_valid[prev_slot]) used <= used | rdata;
    end
    if (state == ST_WRITE && cnt == PCNT_W'(MAX_PTS - 1)) begin
      res_color <= pick.found ? pick.color : '0;
      res_ovf   <= !pick.found;
    end
    if (load_out) begin
      out_data.color       <= res_color;
      out_data.colors_used <= color_count;
      out_data.overflow    <= res_ovf;
    end
  end

endmodule

// ===== rtl/gcc_mem.sv =====
// point mask store: one write port, one read port with registered read data
// depends on gcc_pkg
module gcc_mem
  import gcc_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [MASK_W-1:0] rdata
);

  logic [MASK_W-1:0] mem [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/gcc_pick.sv =====
// two-stage lowest-clear-bit search over the 64-bit busy mask
// depends on gcc_pkg; the result comes out of the stage 2 register
module gcc_pick
  import gcc_pkg::*;
(
  input  logic              clk,
  input  logic [MASK_W-1:0] busy,
  output pick_res_t         pick
);

  logic [GRP_N-1:0]  grp_free;
  logic [SLOT_W-1:0] grp_idx [GRP_N];

  function automatic logic [SLOT_W-1:0] low_zero(input logic [GRP_W-1:0] b);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!b[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  // stage 1: per byte, whether any bit is free and the lowest free position
  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_free[g] <= ~&busy[g*GRP_W +: GRP_W];
      grp_idx[g]  <= low_zero(busy[g*GRP_W +: GRP_W]);
    end
  end

  // stage 2: first byte that has a free bit
  always_ff @(posedge clk) begin
    logic [COLOR_W-1:0] first;
    first = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_free[g]) first = {SLOT_W'(g), grp_idx[g]};
    end
    pick.found <= |grp_free;
    pick.color <= first;
  end

endmodule
